/* hdl/text_mode_terminal_writer_core_macros.svh */
// Assertion macros shared by the checker of the text terminal writer.
// Each macro samples on clk and is held off while arst_n is low.
`ifndef TEXT_MODE_TERMINAL_WRITER_CORE_MACROS_SVH
`define TEXT_MODE_TERMINAL_WRITER_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TTW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TTW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/ttw_pkg.sv */
// Package for the text terminal writer: item types, codes and constants.
// Used by the sequencer, the top level and the checker; depends on nothing.
`default_nettype none

package ttw_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic CFG_FG = 1'b0;
	localparam logic CFG_BG = 1'b1;

	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] BLANK_CODE   = 8'h20;
	localparam logic [3:0] RESET_FG     = 4'hB;
	localparam logic [3:0] RESET_BG     = 4'h0;
	localparam logic [15:0] RESET_BLANK = {RESET_BG, RESET_FG, BLANK_CODE};

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} in_item_t;

	typedef struct packed {
		logic [15:0] cell_data;
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_pos;
		logic        scrolled;
	} out_item_t;

	typedef struct packed {
		logic [3:0] fg;
		logic [3:0] bg;
	} colors_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PUT,
		ST_READ,
		ST_CLEAR,
		ST_SCROLL,
		ST_FILL,
		ST_RESP
	} state_t;

	function automatic logic [15:0] make_cell(logic [7:0] ch, colors_t c);
		return {c.bg, c.fg, ch};
	endfunction

endpackage

`default_nettype wire

/* hdl/ttw_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stands alone; no package needed.
`default_nettype none

module ttw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hdl/ttw_seq.sv */
// Sequencer of the text terminal writer: cursor, screen RAM sweeps and results.
// Depends on ttw_pkg and ttw_ram.
`default_nettype none

module ttw_seq #(
	parameter int COLUMNS = ttw_pkg::DEF_COLUMNS,
	parameter int ROWS    = ttw_pkg::DEF_ROWS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire ttw_pkg::in_item_t  in_item,
	input  wire ttw_pkg::colors_t   colors,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output ttw_pkg::out_item_t      res_item
);

	import ttw_pkg::*;

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int CMP_W  = ((ADDR_W > 11) ? ADDR_W : 11) + 1;

	localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELLS - COLUMNS - 1);
	localparam logic [ADDR_W-1:0] SCROLL_POS = ADDR_W'((ROWS - 1) * COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLUMNS);
	localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

	state_t state_q, state_d;

	logic [7:0]        char_q;
	logic [10:0]       idx_q;
	logic              hit_q;
	logic              scrolled_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] pos_q;
	logic [ADDR_W-1:0] sweep_q;
	logic              cp_v_s1;
	logic [ADDR_W-1:0] cp_dst_s1;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [15:0]       ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [15:0]       ram_rdata;

	logic accept;
	logic in_range;
	logic is_newline;
	logic wrap;
	logic last_row;
	logic [15:0] blank;

	assign accept     = in_valid && in_ready;
	assign in_range   = CMP_W'(in_item.cell_index) < CMP_W'(CELLS);
	assign is_newline = (char_q == NEWLINE_CODE);
	assign wrap       = is_newline || (col_q == LAST_COL);
	assign last_row   = (row_q == LAST_ROW);
	assign blank      = make_cell(BLANK_CODE, colors);

	ttw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = sweep_q;
		ram_wdata = blank;
		ram_re    = 1'b0;
		ram_raddr = sweep_q + ROW_STEP;
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = RESET_BLANK;
				if (sweep_q == LAST_CELL) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_item.action)
						ACT_PUT:   state_d = ST_PUT;
						ACT_READ:  state_d = in_range ? ST_READ : ST_RESP;
						ACT_CLEAR: state_d = ST_CLEAR;
						default:   state_d = ST_RESP;
					endcase
				end
			end
			ST_PUT: begin
				ram_we    = !is_newline;
				ram_waddr = pos_q;
				ram_wdata = make_cell(char_q, colors);
				state_d   = (wrap && last_row) ? ST_SCROLL : ST_RESP;
			end
			ST_READ: begin
				ram_re    = 1'b1;
				ram_raddr = ADDR_W'(idx_q);
				state_d   = ST_RESP;
			end
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (sweep_q == LAST_CELL) begin
					state_d = ST_RESP;
				end
			end
			ST_SCROLL: begin
				ram_re = 1'b1;
				if (sweep_q == COPY_LAST) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				// The last copied row entry still owns the write port as ST_FILL begins.
				ram_we = !cp_v_s1;
				if (!cp_v_s1 && (sweep_q == LAST_CELL)) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (cp_v_s1) begin
			ram_we    = 1'b1;
			ram_waddr = cp_dst_s1;
			ram_wdata = ram_rdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= in_item.char_code;
			idx_q  <= in_item.cell_index;
		end
		cp_dst_s1 <= sweep_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			scrolled_q <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			pos_q      <= '0;
			sweep_q    <= '0;
			cp_v_s1    <= 1'b0;
		end else begin
			cp_v_s1 <= (state_q == ST_SCROLL);
			case (state_q)
				ST_INIT, ST_CLEAR, ST_SCROLL: begin
					sweep_q <= sweep_q + ADDR_W'(1);
				end
				ST_FILL: begin
					if (!cp_v_s1) begin
						sweep_q <= sweep_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						sweep_q    <= '0;
						scrolled_q <= 1'b0;
						hit_q      <= (in_item.action == ACT_READ) && in_range;
						if (in_item.action == ACT_CLEAR) begin
							col_q <= '0;
							row_q <= '0;
							pos_q <= '0;
						end
					end
				end
				ST_PUT: begin
					sweep_q <= '0;
					if (wrap) begin
						col_q <= '0;
						if (last_row) begin
							pos_q      <= SCROLL_POS;
							scrolled_q <= 1'b1;
						end else begin
							row_q <= row_q + ROW_W'(1);
							pos_q <= pos_q - ADDR_W'(col_q) + ROW_STEP;
						end
					end else begin
						col_q <= col_q + COL_W'(1);
						pos_q <= pos_q + ADDR_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res_item.cell_data  = hit_q ? ram_rdata : 16'h0000;
		res_item.cursor_col = 7'(col_q);
		res_item.cursor_row = 5'(row_q);
		res_item.cursor_pos = 11'(pos_q);
		res_item.scrolled   = scrolled_q;
	end

endmodule

`default_nettype wire

/* hdl/text_mode_terminal_writer_core.sv */
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_ready   in_item (action, char_code, cell_index)
// out       output     out_valid/out_ready out_item (cell_data, cursor, scrolled)
// cfg       input      cfg_we              cfg_index, cfg_data (colour nibbles)
//
// A put or read item passes through ST_PUT or ST_READ to ST_RESP; a read past the end of
// the screen goes straight to ST_RESP, and a clear sweeps every cell before ST_RESP.
// A put that scrolls adds a sweep of the screen: the screen RAM's single write port
// copies one cell a cycle, then blanks the bottom row.
// After reset the RAM is blanked before in_ready rises.
// The result register lets the next item be accepted while a result waits.
//
// Top level of the text terminal writer: colour registers and result register.
// Depends on ttw_pkg and ttw_seq.
`default_nettype none

module text_mode_terminal_writer_core #(
	parameter int COLUMNS = ttw_pkg::DEF_COLUMNS,
	parameter int ROWS    = ttw_pkg::DEF_ROWS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire ttw_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output ttw_pkg::out_item_t      out_item,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [3:0]         cfg_data
);

	import ttw_pkg::*;

	colors_t   colors_q;
	logic      out_valid_q;
	out_item_t out_item_q;
	logic      res_valid;
	logic      res_ready;
	out_item_t res_item;

	ttw_seq #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.colors   (colors_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item (res_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors_q.fg <= RESET_FG;
			colors_q.bg <= RESET_BG;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FG:  colors_q.fg <= cfg_data;
				CFG_BG:  colors_q.bg <= cfg_data;
				default: colors_q    <= colors_q;
			endcase
		end
	end

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_item_q <= res_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire

/* hdl/ttw_checker.sv */
// Port-level checker for the text terminal writer, bound to the top level.
// Depends on ttw_pkg and text_mode_terminal_writer_core_macros.svh.
`default_nettype none
`include "text_mode_terminal_writer_core_macros.svh"

module ttw_checker #(
	parameter int COLUMNS = ttw_pkg::DEF_COLUMNS,
	parameter int ROWS    = ttw_pkg::DEF_ROWS
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire ttw_pkg::out_item_t out_item
);

	import ttw_pkg::*;

	// A held result must not change under a stall.
	`TTW_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result changed while stalled")

	// Every item leaves the idle state when accepted, so ready drops after an accept.
	`TTW_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item accepted while busy")

	// The linear position matches the reported row and column; checked only for COLUMNS <= 128 and ROWS <= 32.
	`TTW_ASSERT_IMP(a_pos_linear, out_valid, (COLUMNS > 128) || (ROWS > 32) || (out_item.cursor_pos == 11'(int'(out_item.cursor_row) * COLUMNS + int'(out_item.cursor_col))), "cursor position mismatch")

	// A scroll always leaves the cursor at the start of the last row.
	`TTW_ASSERT_IMP(a_scroll_cursor, out_valid && out_item.scrolled, (out_item.cursor_col == 7'd0) && (out_item.cursor_row == 5'(ROWS - 1)), "bad cursor after scroll")

endmodule

bind text_mode_terminal_writer_core ttw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_ttw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item (out_item)
);

`default_nettype wire
